// File: src/rc6_pkg.sv
// ----------------------------------------------------------------------------
// RC6 pulse encoder package
// Shared payload types, register map, reset values and sequencer states.
// ----------------------------------------------------------------------------
package rc6_pkg;

  localparam int MAX_BITS_DEF     = 32;
  localparam int TRAILER_POS_DEF  = 4;
  localparam int QUEUE_DEPTH_DEF  = 2;

  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 6;
  localparam int TICKS_W  = 15;
  localparam int UNIT_W   = 14;
  localparam int CFG_W    = 15;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_HDR_MARK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HDR_SPACE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT      = 2'd2;

  localparam logic [TICKS_W-1:0] HDR_MARK_RST  = 15'd2128;
  localparam logic [TICKS_W-1:0] HDR_SPACE_RST = 15'd704;
  localparam logic [UNIT_W-1:0]  UNIT_RST      = 14'd352;

  typedef struct packed {
    logic [DATA_W-1:0]  data_word;
    logic [COUNT_W-1:0] bit_count;
  } in_t;

  typedef struct packed {
    logic               first_level;
    logic [TICKS_W-1:0] first_ticks;
    logic               second_level;
    logic [TICKS_W-1:0] second_ticks;
    logic               last_pulse;
  } out_t;

  typedef struct packed {
    logic [TICKS_W-1:0] hdr_mark;
    logic [TICKS_W-1:0] hdr_space;
    logic [UNIT_W-1:0]  unit;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_START,
    BK_DATA
  } bk_state_e;

endpackage

// File: src/rc6_front.sv
// ----------------------------------------------------------------------------
// RC6 front end
// Takes frame requests, saturates the bit count and left-aligns the data so
// the first bit to send sits at the top of the word.
// ----------------------------------------------------------------------------
module rc6_front #(
  parameter int MAX_BITS = rc6_pkg::MAX_BITS_DEF,
  parameter int CNT_W    = $clog2(MAX_BITS + 1)
) (
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rc6_pkg::in_t         in_data_i,
  input  logic                 q_ready_i,
  output logic                 q_push_o,
  output logic [MAX_BITS-1:0]  q_bits_o,
  output logic [CNT_W-1:0]     q_count_o
);
  import rc6_pkg::*;

  localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  logic [CNT_W-1:0]    count_sat;
  logic [CNT_W-1:0]    shift_amt;
  logic [MAX_BITS-1:0] data_ext;

  always_comb begin
    if (CMP_W'(in_data_i.bit_count) > CMP_W'(MAX_BITS)) begin
      count_sat = CNT_W'(MAX_BITS);
    end else begin
      count_sat = CNT_W'(in_data_i.bit_count);
    end
    data_ext  = MAX_BITS'(in_data_i.data_word);
    shift_amt = CNT_W'(MAX_BITS) - count_sat;
  end

  assign q_bits_o   = data_ext << shift_amt;
  assign q_count_o  = count_sat;
  assign q_push_o   = in_valid_i & q_ready_i;
  assign in_stall_o = ~q_ready_i;

endmodule

// File: src/rc6_queue.sv
// ----------------------------------------------------------------------------
// RC6 request queue
// Small flop-based FIFO between the front end and the pulse sequencer.
// ----------------------------------------------------------------------------
module rc6_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rc6_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             ready_o,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign ready_o = (cnt_q != CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: src/rc6_back.sv
// ----------------------------------------------------------------------------
// RC6 pulse sequencer
// Walks one queued frame: header pair, start bit, then Manchester data bits,
// one pulse pair per transfer, into a registered output slot.
// ----------------------------------------------------------------------------
module rc6_back #(
  parameter int MAX_BITS         = rc6_pkg::MAX_BITS_DEF,
  parameter int TRAILER_POSITION = rc6_pkg::TRAILER_POS_DEF,
  parameter int CNT_W            = $clog2(MAX_BITS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rc6_pkg::cfg_t       cfg_i,
  input  logic                q_valid_i,
  output logic                q_pop_o,
  input  logic [MAX_BITS-1:0] q_bits_i,
  input  logic [CNT_W-1:0]    q_count_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rc6_pkg::out_t       out_data_o
);
  import rc6_pkg::*;

  bk_state_e           state_q, state_d;
  logic [MAX_BITS-1:0] bits_q, bits_d;
  logic [CNT_W-1:0]    n_q, n_d;
  logic [CNT_W-1:0]    k_q, k_d;
  logic [CNT_W-1:0]    k_next;
  logic                out_vld_q, out_vld_d;
  out_t                out_q, out_d;
  logic                load;
  logic [TICKS_W-1:0]  unit_ticks;
  logic [TICKS_W-1:0]  dur;
  logic                bit_val;

  assign load       = ~out_vld_q | ~out_stall_i;
  assign unit_ticks = TICKS_W'(cfg_i.unit);
  assign k_next     = k_q + 1'b1;
  assign bit_val    = bits_q[MAX_BITS-1];
  assign dur        = (32'(k_next) == TRAILER_POSITION) ? {cfg_i.unit, 1'b0} : unit_ticks;

  always_comb begin
    state_d   = state_q;
    bits_d    = bits_q;
    n_d       = n_q;
    k_d       = k_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    q_pop_o   = 1'b0;
    if (load) begin
      out_vld_d = 1'b0;
      unique case (state_q)
        BK_IDLE: begin
          if (q_valid_i) begin
            q_pop_o            = 1'b1;
            bits_d             = q_bits_i;
            n_d                = q_count_i;
            out_vld_d          = 1'b1;
            out_d.first_level  = 1'b1;
            out_d.first_ticks  = cfg_i.hdr_mark;
            out_d.second_level = 1'b0;
            out_d.second_ticks = cfg_i.hdr_space;
            out_d.last_pulse   = 1'b0;
            state_d            = BK_START;
          end
        end
        BK_START: begin
          out_vld_d          = 1'b1;
          out_d.first_level  = 1'b1;
          out_d.first_ticks  = unit_ticks;
          out_d.second_level = 1'b0;
          out_d.second_ticks = unit_ticks;
          out_d.last_pulse   = (n_q == '0);
          k_d                = '0;
          state_d            = (n_q == '0) ? BK_IDLE : BK_DATA;
        end
        BK_DATA: begin
          out_vld_d          = 1'b1;
          out_d.first_level  = bit_val;
          out_d.first_ticks  = dur;
          out_d.second_level = ~bit_val;
          out_d.second_ticks = dur;
          out_d.last_pulse   = (k_next == n_q);
          bits_d             = bits_q << 1;
          k_d                = k_next;
          state_d            = (k_next == n_q) ? BK_IDLE : BK_DATA;
        end
        default: begin
          state_d = BK_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      out_vld_q <= 1'b0;
      k_q       <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      k_q       <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
    n_q    <= n_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// File: src/rc6_ir_pulse_encoder.sv
// ----------------------------------------------------------------------------
// RC6 infrared pulse-pair encoder
// Turns a data word and bit count into a header, start bit and Manchester
// coded data bits, each sent as a pulse pair with level and duration.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o | rc6_pkg::in_t
//  out     | output    | out_valid_o/out_stall_i | rc6_pkg::out_t
//  cfg     | input     | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
// A frame of n bits (saturated to MAX_BITS) gives n + 2 pulse pairs, one per
// cycle from the sequencer when out is not stalled. Requests wait in a
// QUEUE_DEPTH entry queue; in stalls only when it is full. Reset empties the
// queue and output slot and loads the default timings.
// ----------------------------------------------------------------------------
module rc6_ir_pulse_encoder #(
  parameter int MAX_BITS         = rc6_pkg::MAX_BITS_DEF,
  parameter int TRAILER_POSITION = rc6_pkg::TRAILER_POS_DEF,
  parameter int QUEUE_DEPTH      = rc6_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rc6_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output rc6_pkg::out_t                   out_data_o,
  input  logic                            cfg_we_i,
  input  logic [rc6_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rc6_pkg::CFG_W-1:0]       cfg_wdata_i
);
  import rc6_pkg::*;

  localparam int CNT_W = $clog2(MAX_BITS + 1);
  localparam int ENT_W = MAX_BITS + CNT_W;

  cfg_t                cfg_q;
  logic                q_push, q_ready, q_pop, q_valid;
  logic [MAX_BITS-1:0] f_bits;
  logic [CNT_W-1:0]    f_count;
  logic [ENT_W-1:0]    q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hdr_mark  <= HDR_MARK_RST;
      cfg_q.hdr_space <= HDR_SPACE_RST;
      cfg_q.unit      <= UNIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HDR_MARK:  cfg_q.hdr_mark  <= cfg_wdata_i;
        REG_HDR_SPACE: cfg_q.hdr_space <= cfg_wdata_i;
        REG_UNIT:      cfg_q.unit      <= cfg_wdata_i[UNIT_W-1:0];
        default: ;
      endcase
    end
  end

  rc6_front #(
    .MAX_BITS (MAX_BITS),
    .CNT_W    (CNT_W)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_bits_o   (f_bits),
    .q_count_o  (f_count)
  );

  rc6_queue #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .ready_o (q_ready),
    .wdata_i ({f_bits, f_count}),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  rc6_back #(
    .MAX_BITS         (MAX_BITS),
    .TRAILER_POSITION (TRAILER_POSITION),
    .CNT_W            (CNT_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_bits_i    (q_rdata[ENT_W-1:CNT_W]),
    .q_count_i   (q_rdata[CNT_W-1:0]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: test/rc6_ir_pulse_encoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RC6 pulse encoder testbench
// Sends data words with bit counts through the request channel and checks
// every pulse pair against a frame encoder kept in the bench. Timing
// registers are changed between pacing phases, including their extremes.
// ----------------------------------------------------------------------------
module rc6_ir_pulse_encoder_test;
  import rc6_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int HOLD_CYCLES = 300;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_t              out_data;
  logic              cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_HDR_MARK;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  in_t  frame_queue[$];
  out_t pairs_due[$];
  cfg_t timing;
  out_t want;

  int   frames_issued = 0;
  int   frames_accepted = 0;
  int   pairs_checked = 0;
  int   settings_used = 1;
  int   errors = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  logic sender_hold = 1'b0;
  logic hold_request = 1'b0;
  logic hold_ack;
  int   hold_left;

  rc6_ir_pulse_encoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // header pair, start bit, then Manchester data bits with the wide trailer
  task automatic encode_frame(input in_t req);
    int n;
    logic bit_v;
    logic [TICKS_W-1:0] dur;
    n = (req.bit_count > MAX_BITS_DEF) ? MAX_BITS_DEF : int'(req.bit_count);
    pairs_due.push_back(out_t'{1'b1, timing.hdr_mark, 1'b0, timing.hdr_space, 1'b0});
    pairs_due.push_back(out_t'{1'b1, TICKS_W'(timing.unit), 1'b0, TICKS_W'(timing.unit),
                               n == 0});
    for (int k = 0; k < n; k++) begin
      bit_v = req.data_word[n - 1 - k];
      dur = (k + 1 == TRAILER_POS_DEF) ? {timing.unit, 1'b0} : TICKS_W'(timing.unit);
      pairs_due.push_back(out_t'{bit_v, dur, ~bit_v, dur, k + 1 == n});
    end
  endtask

  task automatic check_field(input string name, input logic [TICKS_W-1:0] exp_v,
                             input logic [TICKS_W-1:0] got_v);
    if (exp_v != got_v) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  function automatic logic [CFG_W-1:0] rand_ticks();
    return CFG_W'($urandom_range(32767, 0));
  endfunction

  // request driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (!in_valid || !in_stall) begin
      if (!sender_hold && frame_queue.size() != 0 &&
          $urandom_range(99, 0) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= frame_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_ack  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_request != hold_ack) begin
      hold_ack  <= hold_request;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  // monitor: checks each pair transfer, predicts on each request transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pairs_due.size() == 0) begin
          $display("%0t ns: unexpected pulse pair %p", $time, out_data);
          errors++;
        end else begin
          want = pairs_due.pop_front();
          check_field("first_level", TICKS_W'(want.first_level),
                      TICKS_W'(out_data.first_level));
          check_field("first_ticks", want.first_ticks, out_data.first_ticks);
          check_field("second_level", TICKS_W'(want.second_level),
                      TICKS_W'(out_data.second_level));
          check_field("second_ticks", want.second_ticks, out_data.second_ticks);
          check_field("last_pulse", TICKS_W'(want.last_pulse),
                      TICKS_W'(out_data.last_pulse));
          pairs_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        encode_frame(in_data);
        frames_accepted++;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_HDR_MARK: begin
        timing.hdr_mark = val;
      end
      REG_HDR_SPACE: begin
        timing.hdr_space = val;
      end
      REG_UNIT: begin
        timing.unit = val[UNIT_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic set_timing(input logic [CFG_W-1:0] mark, input logic [CFG_W-1:0] space,
                            input logic [CFG_W-1:0] unit_v);
    write_reg(REG_HDR_MARK, mark);
    write_reg(REG_HDR_SPACE, space);
    write_reg(REG_UNIT, unit_v);
    settings_used++;
  endtask

  task automatic set_pace(input int idle, input int stall);
    @(posedge clk);
    send_idle_pct <= idle;
    stall_pct     <= stall;
  endtask

  task automatic queue_frame(input logic [DATA_W-1:0] data, input logic [COUNT_W-1:0] count);
    frame_queue.push_back(in_t'{data, count});
    frames_issued++;
  endtask

  task automatic queue_random(input int count);
    logic [DATA_W-1:0]  data;
    logic [COUNT_W-1:0] bits;
    int pick;
    repeat (count) begin
      data = $urandom();
      pick = $urandom_range(99, 0);
      if (pick < 5) begin
        data = '0;
      end else if (pick < 10) begin
        data = '1;
      end
      pick = $urandom_range(99, 0);
      if (pick < 4) begin
        bits = '0;
      end else if (pick < 10) begin
        bits = COUNT_W'($urandom_range(63, 33));
      end else begin
        bits = COUNT_W'($urandom_range(32, 1));
      end
      queue_frame(data, bits);
    end
  endtask

  // all requests taken and all pairs out, then a short settle
  task automatic wait_idle();
    while (frames_accepted != frames_issued || pairs_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    timing = cfg_t'{HDR_MARK_RST, HDR_SPACE_RST, UNIT_RST};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset timings: empty frame, short frames, trailer edges, saturation
    queue_frame(32'h0000_0000, 6'd0);
    queue_frame(32'hFFFF_FFFF, 6'd1);
    queue_frame(32'h0000_0000, 6'd1);
    queue_frame(32'h0000_0005, 6'd3);
    queue_frame(32'hFFFF_FFF5, 6'd4);
    queue_frame(32'h0000_000A, 6'd5);
    queue_frame(32'h8000_0001, 6'd32);
    queue_frame(32'hAAAA_AAAA, 6'd33);
    queue_frame(32'h5555_5555, 6'd63);
    queue_frame(32'hFFFF_FFFF, 6'd32);
    wait_idle();

    // timing extremes, top end; unit write carries a bit beyond its width
    set_timing(15'h7FFF, 15'h7FFF, 15'h7FFF);
    queue_frame(32'h0000_0009, 6'd4);
    queue_frame(32'h0000_0000, 6'd32);
    queue_frame(32'h0000_0000, 6'd0);
    wait_idle();

    set_timing(15'h0000, 15'h0000, 15'h0000);
    queue_frame(32'hFFFF_FFFF, 6'd6);
    queue_frame(32'h1234_5678, 6'd40);
    wait_idle();

    set_timing(15'h2AAA, 15'h5555, 15'h3FFF);
    write_reg(REG_SPARE, 15'h0123);
    queue_frame(32'hDEAD_BEEF, 6'd32);
    queue_frame(32'h0000_000F, 6'd4);
    queue_frame(32'h0000_0000, 6'd0);
    wait_idle();

    // no idling on either side
    set_timing(rand_ticks(), rand_ticks(), rand_ticks());
    set_pace(0, 0);
    queue_random(46);
    wait_idle();

    set_timing(rand_ticks(), rand_ticks(), rand_ticks());
    set_pace(79, 0);
    queue_random(46);
    wait_idle();

    set_timing(rand_ticks(), rand_ticks(), rand_ticks());
    set_pace(0, 79);
    queue_random(46);
    wait_idle();

    // both sides idling, with the sender paused partway until drained
    set_timing(rand_ticks(), rand_ticks(), rand_ticks());
    set_pace(23, 23);
    queue_random(46);
    while (frames_accepted < frames_issued - 23) @(posedge clk);
    @(posedge clk);
    sender_hold <= 1'b1;
    while (in_valid || pairs_due.size() != 0) @(posedge clk);
    @(posedge clk);
    sender_hold <= 1'b0;
    wait_idle();

    // long receiver hold-off while the sender keeps offering
    set_timing(HDR_MARK_RST, HDR_SPACE_RST, CFG_W'(UNIT_RST));
    set_pace(0, 0);
    @(posedge clk);
    hold_request <= ~hold_request;
    queue_random(46);
    wait_idle();

    repeat (40) @(posedge clk);
    $display("%0d frames, %0d pulse pairs checked", frames_accepted, pairs_checked);
    $display("%0d timing settings, pacing from free-running to heavy stalls", settings_used);
    if (errors == 0) begin
      $display("rc6_ir_pulse_encoder: match");
    end else begin
      $display("rc6_ir_pulse_encoder: mismatch");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d pairs outstanding", pairs_due.size());
    $display("rc6_ir_pulse_encoder: mismatch");
    $finish;
  end

endmodule
